/* sv/ble_pkg.sv */
// Shared types, constants and the sequencer microprogram of the battery level estimator.
// No dependencies; every other file refers to it by scoped names.
package ble_pkg;

	localparam int SAMPLE_W     = 12;
	localparam int CFG_W        = 13;
	localparam int HOLD_W       = 4;
	localparam int LEVEL_W      = 7;
	localparam int MV_W         = 14;
	localparam int ADC_FS_LOG2  = 12;
	localparam int NUM_W        = 26;
	localparam int X_W          = 27;
	localparam int S_W          = 14;
	localparam int N_W          = 36;
	localparam int DVD_W        = 36;
	localparam int DVS_W        = 25;
	localparam int ITER_W       = 6;
	localparam int CFG_IDX_W    = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_REF_MV          = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FULL_MV         = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_MV        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KNEE_MV         = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UPPER_ORIGIN_MV = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_LOWER_ORIGIN_MV = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_STEP       = 3'd6;

	localparam logic [CFG_W-1:0]  REF_MV_RST          = 13'd3100;
	localparam logic [CFG_W-1:0]  FULL_MV_RST         = 13'd4200;
	localparam logic [CFG_W-1:0]  EMPTY_MV_RST        = 13'd3300;
	localparam logic [CFG_W-1:0]  KNEE_MV_RST         = 13'd3650;
	localparam logic [CFG_W-1:0]  UPPER_ORIGIN_MV_RST = 13'd3550;
	localparam logic [CFG_W-1:0]  LOWER_ORIGIN_MV_RST = 13'd3200;
	localparam logic [HOLD_W-1:0] HOLD_STEP_RST       = 4'd4;

	localparam logic [LEVEL_W-1:0] LEVEL_EMPTY = 7'd0;
	localparam logic [LEVEL_W-1:0] LEVEL_FULL  = 7'd100;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_AVG,
		ST_VOLT,
		ST_CLASS,
		ST_SPAN,
		ST_SCALE,
		ST_BASE,
		ST_LVL_LOAD,
		ST_LVL_WAIT,
		ST_CLAMP,
		ST_EMIT,
		ST_DONE
	} step_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_ACCUM,
		OP_AVG,
		OP_MUL_NUM,
		OP_CLASSIFY,
		OP_SPAN,
		OP_MUL_X,
		OP_ADD_BASE,
		OP_DIV_LVL,
		OP_CLAMP,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		C_NEXT,
		C_ALWAYS,
		C_NO_BATCH,
		C_DIV_BUSY,
		C_DIRECT,
		C_SPAN_ZERO,
		C_OUT_BUSY
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} ctrl_word_t;

	typedef struct packed {
		logic              load;
		logic [DVD_W-1:0]  dividend;
		logic [DVS_W-1:0]  divisor;
		logic [ITER_W-1:0] iters;
	} div_cmd_t;

	typedef struct packed {
		logic             busy;
		logic [DVD_W-1:0] quot;
	} div_stat_t;

	// Microprogram: a jump is taken when the condition holds, else fall through.
	function automatic ctrl_word_t seq_rom(input step_t step);
		ctrl_word_t cw;
		begin
			case (step)
				ST_IDLE:     cw = '{OP_ACCUM,    C_NO_BATCH,  ST_IDLE};
				ST_AVG:      cw = '{OP_AVG,      C_NEXT,      ST_IDLE};
				ST_VOLT:     cw = '{OP_MUL_NUM,  C_NEXT,      ST_IDLE};
				ST_CLASS:    cw = '{OP_CLASSIFY, C_DIRECT,    ST_EMIT};
				ST_SPAN:     cw = '{OP_SPAN,     C_NEXT,      ST_IDLE};
				ST_SCALE:    cw = '{OP_MUL_X,    C_SPAN_ZERO, ST_EMIT};
				ST_BASE:     cw = '{OP_ADD_BASE, C_NEXT,      ST_IDLE};
				ST_LVL_LOAD: cw = '{OP_DIV_LVL,  C_NEXT,      ST_IDLE};
				ST_LVL_WAIT: cw = '{OP_NOP,      C_DIV_BUSY,  ST_LVL_WAIT};
				ST_CLAMP:    cw = '{OP_CLAMP,    C_NEXT,      ST_IDLE};
				ST_EMIT:     cw = '{OP_EMIT,     C_OUT_BUSY,  ST_EMIT};
				ST_DONE:     cw = '{OP_NOP,      C_ALWAYS,    ST_IDLE};
				default:     cw = '{OP_NOP,      C_ALWAYS,    ST_IDLE};
			endcase
			return cw;
		end
	endfunction

endpackage

/* sv/battery_level_estimator_top.sv */
// Battery level estimator top level: microcoded sequencer and its datapath.
// Depends on ble_pkg (types, constants, microprogram) and ble_div (percent divider).
//
// Each sample is a one-cycle transaction; samples are summed until NUM_SAMPLES have
// arrived. The last sample of a batch starts the microprogram and closes the sample
// channel until the sequencer is back in its idle step. Above the full or below the empty
// limit the result is emitted directly after classification; a zero segment span skips
// the divider; the linear segments wait for it. The new result also waits in the emit step
// until the previous one is taken. The batch average is a reciprocal multiply; the linear
// segments are set by the restoring divider, which computes the 36-bit percent quotient.
// A waiting result does not block further samples of the next batch; only the next
// batch end waits for it to be taken. Configuration writes take effect at once and
// belong between batches.
module battery_level_estimator_top #(
	parameter int NUM_SAMPLES = 20
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              sample_valid,
	output logic                              sample_ready,
	input  logic [ble_pkg::SAMPLE_W-1:0]      sample,
	output logic                              result_valid,
	input  logic                              result_ready,
	output logic [ble_pkg::LEVEL_W-1:0]       level_percent,
	output logic [ble_pkg::MV_W-1:0]          millivolts,
	output logic                              held,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ble_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ble_pkg::CFG_W-1:0]         cfg_data
);

	localparam int CNT_W     = $clog2(NUM_SAMPLES + 1);
	localparam int SUM_W     = ble_pkg::SAMPLE_W + CNT_W;
	// reciprocal of the batch size, exact for every sum below 2**SUM_W
	localparam int AVG_SHIFT = SUM_W + $clog2(NUM_SAMPLES);
	localparam int RECIP_W   = AVG_SHIFT + 1;
	localparam int PROD_W    = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] AVG_RECIP = RECIP_W'(((longint'(1) <<< AVG_SHIFT)
		+ longint'(NUM_SAMPLES) - 1) / longint'(NUM_SAMPLES));

	// configuration
	logic [ble_pkg::CFG_W-1:0]  ref_q, full_q, empty_q, knee_q, upper_q, lower_q;
	logic [ble_pkg::HOLD_W-1:0] hold_q;

	// sequencer
	ble_pkg::step_t      pc_q, pc_d;
	ble_pkg::ctrl_word_t cw;
	logic                jump;

	// datapath
	logic [SUM_W-1:0]                 sum_q;
	logic [CNT_W-1:0]                 cnt_q;
	logic [ble_pkg::LEVEL_W-1:0]      prev_q;
	logic [ble_pkg::SAMPLE_W-1:0]     avg_q;
	logic [ble_pkg::NUM_W-1:0]        num_q;
	logic signed [ble_pkg::X_W-1:0]   x_q;
	logic signed [ble_pkg::S_W-1:0]   s_q;
	logic signed [ble_pkg::N_W-1:0]   n_q;
	logic                             neg_q;
	logic                             seg_up_q;
	logic [ble_pkg::LEVEL_W-1:0]      level_q;
	logic                             result_valid_q;
	logic [ble_pkg::LEVEL_W-1:0]      level_percent_q;
	logic [ble_pkg::MV_W-1:0]         millivolts_q;
	logic                             held_q;

	logic                             sample_accept;
	logic                             batch_last;
	logic                             out_busy;
	logic                             emit_fire;
	logic                             gt_full, lt_empty, gt_knee, span_zero;
	logic [ble_pkg::CFG_W-1:0]        origin, top;
	logic signed [ble_pkg::N_W-1:0]   x_ext, s_ext, scaled, base_term;
	logic [ble_pkg::DVD_W-1:0]        n_abs;
	logic [ble_pkg::CFG_W-1:0]        s_abs;
	logic [PROD_W-1:0]                avg_prod;
	logic [ble_pkg::LEVEL_W-1:0]      rise;
	logic                             hold_hit;
	logic [ble_pkg::LEVEL_W-1:0]      level_final;
	logic [ble_pkg::DVD_W-1:0]        quot;

	ble_pkg::div_cmd_t  div_cmd;
	ble_pkg::div_stat_t div_stat;

	ble_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (div_cmd),
		.stat   (div_stat)
	);

	assign sample_ready  = (pc_q == ble_pkg::ST_IDLE);
	assign sample_accept = sample_valid && sample_ready;
	assign batch_last    = (cnt_q == CNT_W'(NUM_SAMPLES - 1));
	assign out_busy      = result_valid_q && !result_ready;
	assign cfg_ready     = 1'b1;

	// control word decode
	always_comb begin
		cw = ble_pkg::seq_rom(pc_q);
	end

	// next step
	always_comb begin
		case (cw.cond)
			ble_pkg::C_NEXT:      jump = 1'b0;
			ble_pkg::C_ALWAYS:    jump = 1'b1;
			ble_pkg::C_NO_BATCH:  jump = !(sample_accept && batch_last);
			ble_pkg::C_DIV_BUSY:  jump = div_stat.busy;
			ble_pkg::C_DIRECT:    jump = gt_full || lt_empty;
			ble_pkg::C_SPAN_ZERO: jump = span_zero;
			ble_pkg::C_OUT_BUSY:  jump = out_busy;
			default:              jump = 1'b0;
		endcase
		pc_d = jump ? cw.target : ble_pkg::step_t'(pc_q + 4'd1);
	end

	assign emit_fire = (cw.op == ble_pkg::OP_EMIT) && !out_busy;

	// thresholds compared exactly against avg*2*ref, i.e. millivolts times full scale
	always_comb begin
		gt_full   = num_q > ble_pkg::NUM_W'({full_q, {ble_pkg::ADC_FS_LOG2{1'b0}}});
		lt_empty  = num_q < ble_pkg::NUM_W'({empty_q, {ble_pkg::ADC_FS_LOG2{1'b0}}});
		gt_knee   = num_q > ble_pkg::NUM_W'({knee_q, {ble_pkg::ADC_FS_LOG2{1'b0}}});
		span_zero = (s_q == '0);
		origin    = seg_up_q ? upper_q : lower_q;
		top       = seg_up_q ? full_q : knee_q;
		x_ext     = {{(ble_pkg::N_W - ble_pkg::X_W){x_q[ble_pkg::X_W-1]}}, x_q};
		s_ext     = {{(ble_pkg::N_W - ble_pkg::S_W){s_q[ble_pkg::S_W-1]}}, s_q};
		// spread of 80 on the upper segment, 20 on the lower
		scaled    = seg_up_q ? (x_ext <<< 6) + (x_ext <<< 4) : (x_ext <<< 4) + (x_ext <<< 2);
		// 20 percent base times span times full scale
		base_term = (s_ext <<< (ble_pkg::ADC_FS_LOG2 + 4)) + (s_ext <<< (ble_pkg::ADC_FS_LOG2 + 2));
		n_abs     = n_q[ble_pkg::N_W-1] ? ble_pkg::DVD_W'(-n_q) : ble_pkg::DVD_W'(n_q);
		s_abs     = s_q[ble_pkg::S_W-1] ? ble_pkg::CFG_W'(-s_q) : ble_pkg::CFG_W'(s_q);
		avg_prod  = PROD_W'(sum_q) * PROD_W'(AVG_RECIP);
		quot      = div_stat.quot;
	end

	// hold back a small rise over a nonzero previous level
	always_comb begin
		rise        = level_q - prev_q;
		hold_hit    = (level_q > prev_q) && (rise < ble_pkg::LEVEL_W'(hold_q)) && (prev_q != '0);
		level_final = hold_hit ? prev_q : level_q;
	end

	always_comb begin
		div_cmd = '0;
		case (cw.op)
			ble_pkg::OP_DIV_LVL: begin
				div_cmd.load     = 1'b1;
				div_cmd.dividend = n_abs;
				div_cmd.divisor  = {s_abs, {ble_pkg::ADC_FS_LOG2{1'b0}}};
				div_cmd.iters    = ble_pkg::ITER_W'(ble_pkg::DVD_W);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q           <= ble_pkg::ST_IDLE;
			ref_q          <= ble_pkg::REF_MV_RST;
			full_q         <= ble_pkg::FULL_MV_RST;
			empty_q        <= ble_pkg::EMPTY_MV_RST;
			knee_q         <= ble_pkg::KNEE_MV_RST;
			upper_q        <= ble_pkg::UPPER_ORIGIN_MV_RST;
			lower_q        <= ble_pkg::LOWER_ORIGIN_MV_RST;
			hold_q         <= ble_pkg::HOLD_STEP_RST;
			sum_q          <= '0;
			cnt_q          <= '0;
			prev_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			pc_q <= pc_d;
			if (cfg_valid) begin
				case (cfg_index)
					ble_pkg::CFG_REF_MV:          ref_q   <= cfg_data;
					ble_pkg::CFG_FULL_MV:         full_q  <= cfg_data;
					ble_pkg::CFG_EMPTY_MV:        empty_q <= cfg_data;
					ble_pkg::CFG_KNEE_MV:         knee_q  <= cfg_data;
					ble_pkg::CFG_UPPER_ORIGIN_MV: upper_q <= cfg_data;
					ble_pkg::CFG_LOWER_ORIGIN_MV: lower_q <= cfg_data;
					ble_pkg::CFG_HOLD_STEP:       hold_q  <= cfg_data[ble_pkg::HOLD_W-1:0];
					default: begin
					end
				endcase
			end
			if (emit_fire) begin
				result_valid_q <= 1'b1;
				prev_q         <= level_final;
			end else if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (cw.op)
				ble_pkg::OP_ACCUM: begin
					if (sample_accept) begin
						sum_q <= sum_q + SUM_W'(sample);
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ble_pkg::OP_AVG: begin
					sum_q <= '0;
					cnt_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cw.op)
			ble_pkg::OP_AVG: begin
				avg_q <= avg_prod[AVG_SHIFT +: ble_pkg::SAMPLE_W];
			end
			ble_pkg::OP_MUL_NUM: begin
				num_q <= ble_pkg::NUM_W'({avg_q, 1'b0}) * ble_pkg::NUM_W'(ref_q);
			end
			ble_pkg::OP_CLASSIFY: begin
				level_q  <= gt_full ? ble_pkg::LEVEL_FULL : ble_pkg::LEVEL_EMPTY;
				seg_up_q <= gt_knee;
			end
			ble_pkg::OP_SPAN: begin
				x_q <= $signed({1'b0, num_q}) - $signed({2'b0, origin, {ble_pkg::ADC_FS_LOG2{1'b0}}});
				s_q <= $signed({1'b0, top}) - $signed({1'b0, origin});
			end
			ble_pkg::OP_MUL_X: begin
				n_q     <= scaled;
				// zero span: upper segment reads full, lower reads empty
				level_q <= seg_up_q ? ble_pkg::LEVEL_FULL : ble_pkg::LEVEL_EMPTY;
			end
			ble_pkg::OP_ADD_BASE: begin
				if (seg_up_q) begin
					n_q <= n_q + base_term;
				end
			end
			ble_pkg::OP_DIV_LVL: begin
				neg_q <= n_q[ble_pkg::N_W-1] ^ s_q[ble_pkg::S_W-1];
			end
			ble_pkg::OP_CLAMP: begin
				if (neg_q) begin
					level_q <= ble_pkg::LEVEL_EMPTY;
				end else if (quot > ble_pkg::DVD_W'(ble_pkg::LEVEL_FULL)) begin
					level_q <= ble_pkg::LEVEL_FULL;
				end else begin
					level_q <= quot[ble_pkg::LEVEL_W-1:0];
				end
			end
			ble_pkg::OP_EMIT: begin
				if (!out_busy) begin
					level_percent_q <= level_final;
					millivolts_q    <= num_q[ble_pkg::NUM_W-1:ble_pkg::ADC_FS_LOG2];
					held_q          <= hold_hit;
				end
			end
			default: begin
			end
		endcase
	end

	assign result_valid  = result_valid_q;
	assign level_percent = level_percent_q;
	assign millivolts    = millivolts_q;
	assign held          = held_q;

`ifndef ASSERT_OFF
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> level_percent <= ble_pkg::LEVEL_FULL)
		else $error("level above full scale");

	a_held_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && held |-> level_percent != '0)
		else $error("held at a zero level");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		emit_fire |=> result_valid)
		else $error("emitted transaction not presented");

	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q == ble_pkg::ST_IDLE |-> !div_stat.busy)
		else $error("divider running while idle");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(NUM_SAMPLES))
		else $error("sample count past batch size");
`endif

endmodule

/* sv/ble_div.sv */
// Restoring divider, one quotient bit per cycle, used for the percent quotient.
// Depends on ble_pkg for the command and status structs.
module ble_div (
	input  logic                clk,
	input  logic                arst_n,
	input  ble_pkg::div_cmd_t   cmd,
	output ble_pkg::div_stat_t  stat
);

	logic [ble_pkg::DVD_W-1:0]  dvd_q;
	logic [ble_pkg::DVS_W-1:0]  rem_q;
	logic [ble_pkg::DVS_W-1:0]  dvs_q;
	logic [ble_pkg::ITER_W-1:0] iter_q;

	logic [ble_pkg::DVS_W:0]    trial;
	logic [ble_pkg::DVS_W:0]    diff;
	logic                       fits;
	logic [ble_pkg::DVS_W-1:0]  rem_nx;

	always_comb begin
		trial  = {rem_q, dvd_q[ble_pkg::DVD_W-1]};
		diff   = trial - {1'b0, dvs_q};
		fits   = trial >= {1'b0, dvs_q};
		rem_nx = fits ? diff[ble_pkg::DVS_W-1:0] : trial[ble_pkg::DVS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
		end else if (cmd.load) begin
			iter_q <= cmd.iters;
		end else if (iter_q != '0) begin
			iter_q <= iter_q - 1'b1;
		end
	end

	// Quotient bits shift in at the bottom as dividend bits leave at the top.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dvd_q <= cmd.dividend;
			dvs_q <= cmd.divisor;
			rem_q <= '0;
		end else if (iter_q != '0) begin
			dvd_q <= {dvd_q[ble_pkg::DVD_W-2:0], fits};
			rem_q <= rem_nx;
		end
	end

	assign stat.busy = (iter_q != '0);
	assign stat.quot = dvd_q;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for battery_level_estimator_top: batches of ADC samples in,
// level/millivolt readings out, compared against an in-bench predictor. Needs ble_pkg.
module testbench;

	localparam int BATCH_LEN    = 20;
	localparam longint ADC_FS   = 4096;
	localparam int IDLE_PCT     = 9;
	localparam int DRAIN_CYCLES = 120;
	localparam int CYCLE_LIMIT  = 300000;
	// index with no register behind it; writes must be ignored
	localparam logic [ble_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

	typedef struct packed {
		logic [ble_pkg::LEVEL_W-1:0] level;
		logic [ble_pkg::MV_W-1:0]    mv;
		logic                        held;
	} reading_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          sample_valid = 1'b0;
	logic                          sample_ready;
	logic [ble_pkg::SAMPLE_W-1:0]  sample = '0;
	logic                          result_valid;
	logic                          result_ready = 1'b0;
	logic [ble_pkg::LEVEL_W-1:0]   level_percent;
	logic [ble_pkg::MV_W-1:0]      millivolts;
	logic                          held;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [ble_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [ble_pkg::CFG_W-1:0]     cfg_data = '0;

	// predictor copy of the registers and batch state
	logic [ble_pkg::CFG_W-1:0]     ref_mv_q;
	logic [ble_pkg::CFG_W-1:0]     full_mv_q;
	logic [ble_pkg::CFG_W-1:0]     empty_mv_q;
	logic [ble_pkg::CFG_W-1:0]     knee_mv_q;
	logic [ble_pkg::CFG_W-1:0]     upper_origin_q;
	logic [ble_pkg::CFG_W-1:0]     lower_origin_q;
	logic [ble_pkg::HOLD_W-1:0]    hold_step_q;
	logic [16:0]                   batch_sum = '0;
	int                            batch_count = 0;
	logic [ble_pkg::LEVEL_W-1:0]   last_level = '0;

	reading_t                      expected_readings[$];
	int                            mismatch_count = 0;
	int                            cycle_count = 0;
	logic                          idle_on = 1'b1;
	int                            last_target = 2048;

	battery_level_estimator_top #(
		.NUM_SAMPLES(BATCH_LEN)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample(sample),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.level_percent(level_percent),
		.millivolts(millivolts),
		.held(held),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		result_ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		reading_t exp_r;
		if (arst_n && result_valid && result_ready) begin
			if (expected_readings.size() == 0) begin
				$display("%0t: unexpected reading level=%0d mv=%0d held=%0d",
					$time, level_percent, millivolts, held);
				mismatch_count++;
			end else begin
				exp_r = expected_readings.pop_front();
				if (level_percent !== exp_r.level) begin
					$display("%0t: level_percent expected %0d actual %0d",
						$time, exp_r.level, level_percent);
					mismatch_count++;
				end
				if (millivolts !== exp_r.mv) begin
					$display("%0t: millivolts expected %0d actual %0d",
						$time, exp_r.mv, millivolts);
					mismatch_count++;
				end
				if (held !== exp_r.held) begin
					$display("%0t: held expected %0d actual %0d", $time, exp_r.held, held);
					mismatch_count++;
				end
			end
		end
	end

	function automatic void load_reset_settings();
		ref_mv_q       = ble_pkg::REF_MV_RST;
		full_mv_q      = ble_pkg::FULL_MV_RST;
		empty_mv_q     = ble_pkg::EMPTY_MV_RST;
		knee_mv_q      = ble_pkg::KNEE_MV_RST;
		upper_origin_q = ble_pkg::UPPER_ORIGIN_MV_RST;
		lower_origin_q = ble_pkg::LOWER_ORIGIN_MV_RST;
		hold_step_q    = ble_pkg::HOLD_STEP_RST;
	endfunction

	function automatic void apply_reg(input logic [ble_pkg::CFG_IDX_W-1:0] idx,
			input logic [ble_pkg::CFG_W-1:0] data);
		case (idx)
			ble_pkg::CFG_REF_MV:          ref_mv_q = data;
			ble_pkg::CFG_FULL_MV:         full_mv_q = data;
			ble_pkg::CFG_EMPTY_MV:        empty_mv_q = data;
			ble_pkg::CFG_KNEE_MV:         knee_mv_q = data;
			ble_pkg::CFG_UPPER_ORIGIN_MV: upper_origin_q = data;
			ble_pkg::CFG_LOWER_ORIGIN_MV: lower_origin_q = data;
			ble_pkg::CFG_HOLD_STEP:       hold_step_q = data[ble_pkg::HOLD_W-1:0];
			default: ;
		endcase
	endfunction

	// linear percent on one segment, truncated toward zero; zero span gives a fixed value
	function automatic longint segment_percent(input longint num, input longint origin,
			input longint top, input longint base, input longint spread,
			input longint degenerate);
		longint span;
		longint numer;
		span = (top - origin) * ADC_FS;
		if (span == 0)
			return degenerate;
		numer = (num - origin * ADC_FS) * spread + base * span;
		return numer / span;
	endfunction

	function automatic reading_t next_reading(input logic [16:0] total);
		longint avg;
		longint num;
		longint volts;
		longint lvl;
		reading_t r;
		avg = longint'(total) / BATCH_LEN;
		num = avg * 2 * longint'(ref_mv_q);
		volts = num / ADC_FS;
		if (volts > 16383)
			volts = 16383;
		if (num > longint'(full_mv_q) * ADC_FS)
			lvl = 100;
		else if (num < longint'(empty_mv_q) * ADC_FS)
			lvl = 0;
		else if (num > longint'(knee_mv_q) * ADC_FS)
			lvl = segment_percent(num, longint'(upper_origin_q), longint'(full_mv_q),
				20, 80, 100);
		else
			lvl = segment_percent(num, longint'(lower_origin_q), longint'(knee_mv_q),
				0, 20, 0);
		if (lvl < 0)
			lvl = 0;
		if (lvl > 100)
			lvl = 100;
		r.held = 1'b0;
		// hold back a small rise over a nonzero previous level
		if (lvl > longint'(last_level) && lvl - longint'(last_level) < longint'(hold_step_q)
				&& last_level != 0) begin
			lvl = longint'(last_level);
			r.held = 1'b1;
		end
		r.level = lvl[ble_pkg::LEVEL_W-1:0];
		r.mv = volts[ble_pkg::MV_W-1:0];
		last_level = r.level;
		return r;
	endfunction

	task automatic send_sample(input logic [ble_pkg::SAMPLE_W-1:0] value);
		while (idle_on && $urandom_range(99) < IDLE_PCT) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= value;
		@(posedge clk);
		while (!sample_ready)
			@(posedge clk);
		batch_sum = batch_sum + value;
		batch_count++;
		if (batch_count == BATCH_LEN) begin
			expected_readings.push_back(next_reading(batch_sum));
			batch_sum = '0;
			batch_count = 0;
		end
	endtask

	task automatic write_reg(input logic [ble_pkg::CFG_IDX_W-1:0] idx,
			input logic [ble_pkg::CFG_W-1:0] data);
		while (idle_on && $urandom_range(99) < IDLE_PCT) begin
			cfg_valid <= 1'b0;
			@(posedge clk);
		end
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		apply_reg(idx, data);
	endtask

	task automatic configure(input int ref_mv, input int full_mv, input int empty_mv,
			input int knee_mv, input int upper_mv, input int lower_mv, input int hold_data);
		write_reg(ble_pkg::CFG_REF_MV, ref_mv[ble_pkg::CFG_W-1:0]);
		write_reg(ble_pkg::CFG_FULL_MV, full_mv[ble_pkg::CFG_W-1:0]);
		write_reg(ble_pkg::CFG_EMPTY_MV, empty_mv[ble_pkg::CFG_W-1:0]);
		write_reg(ble_pkg::CFG_KNEE_MV, knee_mv[ble_pkg::CFG_W-1:0]);
		write_reg(ble_pkg::CFG_UPPER_ORIGIN_MV, upper_mv[ble_pkg::CFG_W-1:0]);
		write_reg(ble_pkg::CFG_LOWER_ORIGIN_MV, lower_mv[ble_pkg::CFG_W-1:0]);
		write_reg(ble_pkg::CFG_HOLD_STEP, hold_data[ble_pkg::CFG_W-1:0]);
		cfg_valid <= 1'b0;
	endtask

	// close the sample channel, drain the readings and let the sequencer settle
	task automatic end_phase();
		sample_valid <= 1'b0;
		while (expected_readings.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_batch(input int target, input int jitter);
		int v;
		for (int i = 0; i < BATCH_LEN; i++) begin
			v = target - jitter + int'($urandom_range(2 * jitter));
			if (v < 0)
				v = 0;
			if (v > 4095)
				v = 4095;
			send_sample(v[ble_pkg::SAMPLE_W-1:0]);
		end
		last_target = target;
	endtask

	// batch average that mostly lands around the thresholds of the current settings, else random
	function automatic int pick_target();
		longint lo_mv;
		longint hi_mv;
		longint v;
		longint avg;
		if (ref_mv_q == 0 || $urandom_range(99) < 15)
			return $urandom_range(4095);
		lo_mv = longint'(empty_mv_q);
		if (longint'(knee_mv_q) < lo_mv)
			lo_mv = longint'(knee_mv_q);
		if (longint'(lower_origin_q) < lo_mv)
			lo_mv = longint'(lower_origin_q);
		hi_mv = longint'(full_mv_q);
		if (longint'(knee_mv_q) > hi_mv)
			hi_mv = longint'(knee_mv_q);
		if (longint'(upper_origin_q) > hi_mv)
			hi_mv = longint'(upper_origin_q);
		lo_mv = (lo_mv > 100) ? lo_mv - 100 : 0;
		hi_mv = hi_mv + 100;
		v = lo_mv + longint'($urandom_range(int'(hi_mv - lo_mv)));
		avg = v * ADC_FS / (2 * longint'(ref_mv_q));
		return (avg > 4095) ? 4095 : int'(avg);
	endfunction

	task automatic run_random_batches(input int count);
		int roll;
		int target;
		for (int b = 0; b < count; b++) begin
			roll = $urandom_range(99);
			if (roll < 25) begin
				// small rise over the last batch to provoke the hold
				target = last_target + int'($urandom_range(40));
				if (target > 4095)
					target = 4095;
				send_batch(target, $urandom_range(4));
			end else if (roll < 40) begin
				send_batch(2048, 2048);
			end else begin
				send_batch(pick_target(), $urandom_range(16));
			end
		end
	endtask

	task automatic test_sample_extremes();
		for (int i = 0; i < BATCH_LEN; i++)
			send_sample((i % 2 == 0) ? 12'hFFF : 12'h000);
		end_phase();
	endtask

	task automatic test_reset_settings();
		run_random_batches(10);
		idle_on <= 1'b0;
		run_random_batches(10);
		idle_on <= 1'b1;
		end_phase();
	endtask

	task automatic test_register_extremes();
		configure(1000, 8191, 0, 8191, 0, 0, 15);
		run_random_batches(6);
		end_phase();
		configure(8191, 0, 8191, 0, 8191, 8191, 0);
		run_random_batches(6);
		end_phase();
	endtask

	task automatic test_degenerate_spans();
		configure(3100, 4000, 3300, 3500, 4000, 3500, 4);
		run_random_batches(8);
		end_phase();
	endtask

	task automatic test_out_of_range_levels();
		// reversed upper span overshoots 100; origin above the voltage undershoots 0
		configure(3100, 4180, 3000, 3650, 4190, 3400, 2);
		run_random_batches(8);
		end_phase();
	endtask

	task automatic test_hold_ramp();
		int target;
		configure(3100, 4200, 3300, 3650, 3550, 3200, 15);
		target = 2444;
		for (int b = 0; b < 12; b++) begin
			send_batch(target, $urandom_range(4));
			target = target + 5 + int'($urandom_range(20));
		end
		end_phase();
	endtask

	task automatic test_random_settings();
		int ref_mv;
		int empty_mv;
		int knee_mv;
		int full_mv;
		for (int s = 0; s < 8; s++) begin
			ref_mv = ($urandom_range(99) < 80) ? $urandom_range(1000, 5000) : $urandom_range(8191);
			if ($urandom_range(99) < 70) begin
				empty_mv = $urandom_range(2500, 3500);
				knee_mv = empty_mv + $urandom_range(600);
				full_mv = knee_mv + $urandom_range(900);
				configure(ref_mv, full_mv, empty_mv, knee_mv,
					knee_mv - int'($urandom_range(200)), empty_mv - int'($urandom_range(200)),
					int'({9'($urandom_range(511)), 4'($urandom_range(15))}));
			end else begin
				configure(ref_mv, $urandom_range(8191), $urandom_range(8191),
					$urandom_range(8191), $urandom_range(8191), $urandom_range(8191),
					$urandom_range(8191));
			end
			if (s == 3) begin
				write_reg(CFG_SPARE, ble_pkg::CFG_W'($urandom_range(8191)));
				cfg_valid <= 1'b0;
			end
			run_random_batches(4);
			end_phase();
		end
	endtask

	initial begin
		load_reset_settings();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_sample_extremes();
		test_reset_settings();
		test_register_extremes();
		test_degenerate_spans();
		test_out_of_range_levels();
		test_hold_ramp();
		test_random_settings();
		end_phase();
		if (mismatch_count == 0 && expected_readings.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
